[rtl/core/tclp_pkg.sv]
// Shared types, constants and lookup functions for the tuning command line parser.
package tclp_pkg;

    localparam int LINE_CAP = 64;
    localparam int LEN_W    = $clog2(LINE_CAP);

    localparam logic [1:0] KIND_GET     = 2'd0;
    localparam logic [1:0] KIND_LINE    = 2'd1;
    localparam logic [1:0] KIND_CRUISE  = 2'd2;
    localparam logic [1:0] KIND_INVALID = 2'd3;

    localparam int OUT_W = 120;

    typedef struct packed {
        logic accept;
        logic div_step;
        logic emit;
    } tclp_cmd_t;

    typedef struct packed {
        logic div_start;
        logic div_last;
        logic is_lf;
    } tclp_stat_t;

    function automatic logic [7:0] get_char(input logic [3:0] idx);
        logic [7:0] c;
        unique case (idx)
            4'd0:    c = "G";
            4'd1:    c = "E";
            4'd2:    c = "T";
            4'd3:    c = ",";
            4'd4:    c = "C";
            4'd5:    c = "O";
            4'd6:    c = "N";
            4'd7:    c = "F";
            4'd8:    c = "I";
            4'd9:    c = "G";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] line_char(input logic [3:0] idx);
        logic [7:0] c;
        unique case (idx)
            4'd0:    c = "I";
            4'd1:    c = "N";
            4'd2:    c = "E";
            4'd3:    c = ",";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] cruise_char(input logic [3:0] idx);
        logic [7:0] c;
        unique case (idx)
            4'd0:    c = "R";
            4'd1:    c = "U";
            4'd2:    c = "I";
            4'd3:    c = "S";
            4'd4:    c = "E";
            4'd5:    c = ",";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [16:0] pow10(input logic [2:0] n);
        logic [16:0] p;
        unique case (n)
            3'd1:    p = 17'd10;
            3'd2:    p = 17'd100;
            3'd3:    p = 17'd1000;
            3'd4:    p = 17'd10000;
            3'd5:    p = 17'd100000;
            default: p = 17'd1;
        endcase
        return p;
    endfunction

endpackage

[rtl/core/tuning_command_line_parser.sv]
// Top level of the tuning command line parser: byte stream in, one command per line out.
// Timing: a byte that closes a gain field with a fraction is followed by the fraction scaling in
//   state ST_DIV; LF passes through state ST_EMIT before the result transaction is offered.
// Throughput: one byte per cycle, except that intake stops during the fraction scaling;
//   an LF byte also holds intake until the output register is free.
// Reset: rst_n clears the line, the parse state and the output valid; no clearing pass.
module tuning_command_line_parser (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] rx_byte
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [119:0] m_tdata    // [1:0] cmd_kind, [33:2] gain_p, [65:34] gain_i,
                                    // [97:66] gain_d, [112:98] cruise_value, rest zero
);
    import tclp_pkg::*;

    tclp_cmd_t  cmd;
    tclp_stat_t stat;

    tclp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tclp_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_byte  (s_tdata),
        .cmd      (cmd),
        .stat     (stat),
        .out_data (m_tdata)
    );

    a_no_intake_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> !s_tready)
        else $error("byte intake during fraction scaling");

    a_lf_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tdata == 8'h0A) |=> !s_tready)
        else $error("intake continued right after line end");

    a_gains_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[1:0] != KIND_LINE) |-> (m_tdata[97:2] == '0))
        else $error("gains nonzero outside set_line_gains");

endmodule

[rtl/core/tclp_ctrl.sv]
// Controller state machine: byte intake, fraction division sequencing, result hand-off.
module tclp_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  tclp_pkg::tclp_stat_t stat,
    output tclp_pkg::tclp_cmd_t  cmd
);
    import tclp_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       lf_reg, lf_next;
    logic       valid_reg, valid_next;
    logic       out_free;

    assign out_free = !valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = valid_reg;

    always_comb
    begin
        state_next   = state_reg;
        lf_next      = lf_reg;
        valid_next   = valid_reg && !m_tready;
        cmd.accept   = 1'b0;
        cmd.div_step = 1'b0;
        cmd.emit     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    lf_next    = stat.is_lf;
                    if (stat.div_start)
                        state_next = ST_DIV;
                    else if (stat.is_lf)
                        state_next = ST_EMIT;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                    state_next = lf_reg ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    cmd.emit   = 1'b1;
                    valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            lf_reg    <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            lf_reg    <= lf_next;
            valid_reg <= valid_next;
        end
    end

endmodule

[rtl/core/tclp_dp.sv]
// Datapath: line bookkeeping, streaming command parse, gain fraction scaling, result register.
module tclp_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [7:0]                    rx_byte,
    input  tclp_pkg::tclp_cmd_t           cmd,
    output tclp_pkg::tclp_stat_t          stat,
    output logic [tclp_pkg::OUT_W-1:0]    out_data
);
    import tclp_pkg::*;

    localparam logic [4:0] PH_START = 5'd0;
    localparam logic [4:0] PH_G     = 5'd1;
    localparam logic [4:0] PH_S     = 5'd2;
    localparam logic [4:0] PH_SEL   = 5'd3;
    localparam logic [4:0] PH_L     = 5'd4;
    localparam logic [4:0] PH_C     = 5'd5;
    localparam logic [4:0] PH_GDONE = 5'd6;
    localparam logic [4:0] PH_SIGN  = 5'd7;
    localparam logic [4:0] PH_INT0  = 5'd8;
    localparam logic [4:0] PH_INT   = 5'd9;
    localparam logic [4:0] PH_DOT   = 5'd10;
    localparam logic [4:0] PH_FRAC  = 5'd11;
    localparam logic [4:0] PH_CRU0  = 5'd12;
    localparam logic [4:0] PH_CRU   = 5'd13;
    localparam logic [4:0] PH_OKG   = 5'd14;
    localparam logic [4:0] PH_OKL   = 5'd15;
    localparam logic [4:0] PH_OKC   = 5'd16;
    localparam logic [4:0] PH_FAIL  = 5'd17;

    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_NUL = 8'h00;

    // ceil(2^43 / 3125): x * 65536 / 100000 == (x * FRAC_RECIP) >> 32 for x < 100000
    localparam logic [31:0] FRAC_RECIP = 32'd2814749768;

    logic [LEN_W-1:0] len_reg, len_next;
    logic             ovf_reg, ovf_next;
    logic             ended_reg, ended_next;
    logic [4:0]       phase_reg, phase_next;
    logic [3:0]       idx_reg, idx_next;
    logic [1:0]       gidx_reg, gidx_next;
    logic [1:0]       widx_reg, widx_next;
    logic             neg_reg, neg_next;
    logic [14:0]      int_reg, int_next;
    logic [16:0]      frac_reg, frac_next;
    logic [2:0]       nfrac_reg, nfrac_next;
    logic [15:0]      cru_reg, cru_next;
    logic             cnt_reg, cnt_next;
    logic [31:0]      gain_reg [3];
    logic [31:0]      gain_next [3];
    logic [OUT_W-1:0] out_reg, out_next;

    logic        is_dig, do_char, do_end, fin_now, fin_div;
    logic [3:0]  dig;
    logic [18:0] int_mul;
    logic [19:0] cru_mul;
    logic [16:0] scale;
    logic [33:0] norm;
    logic [48:0] recip;
    logic [31:0] mag;
    logic [1:0]  kind;

    assign out_data = out_reg;

    always_comb
    begin
        is_dig  = (rx_byte >= "0") && (rx_byte <= "9");
        dig     = rx_byte[3:0] - 4'd0;
        int_mul = {4'b0, int_reg} * 19'd10 + {15'b0, dig};
        cru_mul = {4'b0, cru_reg} * 20'd10 + {16'b0, dig};
        scale   = pow10(3'd5 - nfrac_reg);
        norm    = {17'b0, frac_reg} * {17'b0, scale};
        recip   = {32'b0, frac_reg} * {17'b0, FRAC_RECIP};

        len_next   = len_reg;
        ovf_next   = ovf_reg;
        ended_next = ended_reg;
        phase_next = phase_reg;
        idx_next   = idx_reg;
        gidx_next  = gidx_reg;
        widx_next  = widx_reg;
        neg_next   = neg_reg;
        int_next   = int_reg;
        frac_next  = frac_reg;
        nfrac_next = nfrac_reg;
        cru_next   = cru_reg;
        cnt_next   = cnt_reg;
        gain_next  = gain_reg;
        out_next   = out_reg;
        do_char    = 1'b0;
        do_end     = 1'b0;
        fin_now    = 1'b0;
        fin_div    = 1'b0;
        mag        = {1'b0, int_reg, 16'b0};

        stat.is_lf    = (rx_byte == CH_LF);
        stat.div_last = (cnt_reg == 1'b1);
        stat.div_start = 1'b0;

        if (cmd.accept)
        begin
            if (rx_byte == CH_LF)
                do_end = !ended_reg;
            else if (rx_byte != CH_CR)
            begin
                if (len_reg < LEN_W'(LINE_CAP - 1))
                begin
                    len_next = len_reg + LEN_W'(1);
                    if (!ended_reg)
                    begin
                        if (rx_byte == CH_NUL)
                        begin
                            do_end     = 1'b1;
                            ended_next = 1'b1;
                        end
                        else
                            do_char = 1'b1;
                    end
                end
                else
                    ovf_next = 1'b1;
            end
        end

        if (do_char)
        begin
            unique case (phase_reg)
                PH_START:
                begin
                    idx_next = 4'd1;
                    if (rx_byte == "G")
                        phase_next = PH_G;
                    else if (rx_byte == "S")
                        phase_next = PH_S;
                    else
                        phase_next = PH_FAIL;
                end
                PH_G:
                begin
                    idx_next = idx_reg + 4'd1;
                    if (rx_byte != get_char(idx_reg))
                        phase_next = PH_FAIL;
                    else if (idx_reg == 4'd9)
                        phase_next = PH_GDONE;
                end
                PH_S:
                begin
                    idx_next = idx_reg + 4'd1;
                    if (rx_byte != get_char(idx_reg))
                        phase_next = PH_FAIL;
                    else if (idx_reg == 4'd3)
                        phase_next = PH_SEL;
                end
                PH_SEL:
                begin
                    idx_next = 4'd0;
                    if (rx_byte == "L")
                        phase_next = PH_L;
                    else if (rx_byte == "C")
                        phase_next = PH_C;
                    else
                        phase_next = PH_FAIL;
                end
                PH_L:
                begin
                    idx_next = idx_reg + 4'd1;
                    if (rx_byte != line_char(idx_reg))
                        phase_next = PH_FAIL;
                    else if (idx_reg == 4'd3)
                        phase_next = PH_SIGN;
                end
                PH_C:
                begin
                    idx_next = idx_reg + 4'd1;
                    if (rx_byte != cruise_char(idx_reg))
                        phase_next = PH_FAIL;
                    else if (idx_reg == 4'd5)
                        phase_next = PH_CRU0;
                end
                PH_SIGN:
                begin
                    if (rx_byte == "+" || rx_byte == "-")
                    begin
                        neg_next   = (rx_byte == "-");
                        phase_next = PH_INT0;
                    end
                    else if (is_dig)
                    begin
                        int_next   = {11'b0, dig};
                        phase_next = PH_INT;
                    end
                    else
                        phase_next = PH_FAIL;
                end
                PH_INT0:
                begin
                    if (is_dig)
                    begin
                        int_next   = {11'b0, dig};
                        phase_next = PH_INT;
                    end
                    else
                        phase_next = PH_FAIL;
                end
                PH_INT:
                begin
                    if (is_dig)
                        int_next = (int_mul > 19'd32767) ? 15'd32767 : int_mul[14:0];
                    else if (rx_byte == ".")
                        phase_next = PH_DOT;
                    else if (rx_byte == "," && gidx_reg != 2'd2)
                    begin
                        fin_now    = 1'b1;
                        gidx_next  = gidx_reg + 2'd1;
                        phase_next = PH_SIGN;
                    end
                    else
                        phase_next = PH_FAIL;
                end
                PH_DOT:
                begin
                    if (is_dig)
                    begin
                        frac_next  = {13'b0, dig};
                        nfrac_next = 3'd1;
                        phase_next = PH_FRAC;
                    end
                    else
                        phase_next = PH_FAIL;
                end
                PH_FRAC:
                begin
                    if (is_dig)
                    begin
                        if (nfrac_reg < 3'd5)
                        begin
                            frac_next  = 17'(frac_reg * 17'd10 + {13'b0, dig});
                            nfrac_next = nfrac_reg + 3'd1;
                        end
                    end
                    else if (rx_byte == "," && gidx_reg != 2'd2)
                    begin
                        fin_div    = 1'b1;
                        gidx_next  = gidx_reg + 2'd1;
                        phase_next = PH_SIGN;
                    end
                    else
                        phase_next = PH_FAIL;
                end
                PH_CRU0:
                begin
                    if (is_dig)
                    begin
                        cru_next   = {12'b0, dig};
                        phase_next = PH_CRU;
                    end
                    else
                        phase_next = PH_FAIL;
                end
                PH_CRU:
                begin
                    if (is_dig && cru_reg <= 16'd3276)
                        cru_next = cru_mul[15:0];
                    else
                        phase_next = PH_FAIL;
                end
                default:
                begin
                    phase_next = PH_FAIL;
                end
            endcase
        end

        if (do_end)
        begin
            priority if (phase_reg == PH_GDONE)
                phase_next = PH_OKG;
            else if (phase_reg == PH_INT && gidx_reg == 2'd2)
            begin
                fin_now    = 1'b1;
                phase_next = PH_OKL;
            end
            else if (phase_reg == PH_FRAC && gidx_reg == 2'd2)
            begin
                fin_div    = 1'b1;
                phase_next = PH_OKL;
            end
            else if (phase_reg == PH_CRU && cru_reg <= 16'd32767)
                phase_next = PH_OKC;
            else
                phase_next = PH_FAIL;
        end

        if (fin_now)
        begin
            gain_next[gidx_reg] = neg_reg ? (32'd0 - mag) : mag;
            int_next = 15'd0;
            neg_next = 1'b0;
        end

        if (fin_div)
        begin
            stat.div_start = 1'b1;
            widx_next      = gidx_reg;
            cnt_next       = 1'b0;
        end

        // First step widens the fraction to five digits, second step scales it to 16 bits.
        if (cmd.div_step)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == 1'b0)
                frac_next = norm[16:0];
            else
            begin
                mag = {1'b0, int_reg, recip[47:32]};
                gain_next[widx_reg] = neg_reg ? (32'd0 - mag) : mag;
                int_next   = 15'd0;
                neg_next   = 1'b0;
                frac_next  = 17'd0;
                nfrac_next = 3'd0;
            end
        end

        if (ovf_reg || len_reg == LEN_W'(0))
            kind = KIND_INVALID;
        else if (phase_reg == PH_OKG)
            kind = KIND_GET;
        else if (phase_reg == PH_OKL)
            kind = KIND_LINE;
        else if (phase_reg == PH_OKC)
            kind = KIND_CRUISE;
        else
            kind = KIND_INVALID;

        if (cmd.emit)
        begin
            out_next = '0;
            out_next[1:0] = kind;
            if (kind == KIND_LINE)
            begin
                out_next[33:2]  = gain_reg[0];
                out_next[65:34] = gain_reg[1];
                out_next[97:66] = gain_reg[2];
            end
            if (kind == KIND_CRUISE)
                out_next[112:98] = cru_reg[14:0];
            len_next   = '0;
            ovf_next   = 1'b0;
            ended_next = 1'b0;
            phase_next = PH_START;
            idx_next   = 4'd0;
            gidx_next  = 2'd0;
            neg_next   = 1'b0;
            int_next   = 15'd0;
            frac_next  = 17'd0;
            nfrac_next = 3'd0;
            cru_next   = 16'd0;
            gain_next[0] = 32'd0;
            gain_next[1] = 32'd0;
            gain_next[2] = 32'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg   <= '0;
            ovf_reg   <= 1'b0;
            ended_reg <= 1'b0;
            phase_reg <= PH_START;
            idx_reg   <= 4'd0;
            gidx_reg  <= 2'd0;
            widx_reg  <= 2'd0;
            neg_reg   <= 1'b0;
            int_reg   <= 15'd0;
            frac_reg  <= 17'd0;
            nfrac_reg <= 3'd0;
            cru_reg   <= 16'd0;
            cnt_reg   <= 1'b0;
            gain_reg[0] <= 32'd0;
            gain_reg[1] <= 32'd0;
            gain_reg[2] <= 32'd0;
        end
        else
        begin
            len_reg   <= len_next;
            ovf_reg   <= ovf_next;
            ended_reg <= ended_next;
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            gidx_reg  <= gidx_next;
            widx_reg  <= widx_next;
            neg_reg   <= neg_next;
            int_reg   <= int_next;
            frac_reg  <= frac_next;
            nfrac_reg <= nfrac_next;
            cru_reg   <= cru_next;
            cnt_reg   <= cnt_next;
            gain_reg  <= gain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
    end

endmodule
